[design/assert_macros.svh]
// Assertion macros used by the parser core.
// No dependencies; each macro expects a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define PSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PSFP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/psfp_pkg.sv]
// Shared types and constants for the particle sensor frame parser.
// No dependencies.
`default_nettype none

package psfp_pkg;

  localparam int FRAME_BYTES_DEF = 32;

  localparam logic [7:0]  HDR_FIRST  = 8'h42;
  localparam logic [7:0]  HDR_SECOND = 8'h4D;
  localparam logic [15:0] HDR_SUM    = 16'h008F;

  // Frame positions of the captured reading bytes
  localparam int PM1_HI_POS  = 4;
  localparam int PM1_LO_POS  = 5;
  localparam int PM25_HI_POS = 6;
  localparam int PM25_LO_POS = 7;
  localparam int PM10_HI_POS = 8;
  localparam int PM10_LO_POS = 9;
  localparam int FIRST_DATA_POS = 2;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
    logic        checksum_ok;
  } result_t;

endpackage

`default_nettype wire

[design/psfp_in_stage.sv]
// Input register of the parser: holds one received byte until the frame logic takes it.
// No package dependencies.
`default_nettype none

module psfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            q_valid,
  output logic [7:0]      q_byte
);

  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

[design/psfp_frame_fsm.sv]
// Header hunt, frame byte counter, running checksum and reading capture.
// Depends on psfp_pkg.
`default_nettype none

module psfp_frame_fsm #(
  parameter int FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx,
  output logic             emit,
  output psfp_pkg::result_t res
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] CHK_IDX  = IDX_W'(FRAME_BYTES - 2);

  psfp_pkg::phase_t phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [15:0]      pm1_reg, pm1_reg_next;
  logic [15:0]      pm25_reg, pm25_reg_next;
  logic [15:0]      pm10_reg, pm10_reg_next;
  logic [7:0]       check_high, check_high_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= psfp_pkg::PH_HUNT;
      byte_index  <= '0;
      running_sum <= '0;
      pm1_reg     <= '0;
      pm25_reg    <= '0;
      pm10_reg    <= '0;
      check_high  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      pm1_reg     <= pm1_reg_next;
      pm25_reg    <= pm25_reg_next;
      pm10_reg    <= pm10_reg_next;
      check_high  <= check_high_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    pm1_reg_next     = pm1_reg;
    pm25_reg_next    = pm25_reg;
    pm10_reg_next    = pm10_reg;
    check_high_next  = check_high;
    emit             = 1'b0;

    unique case (phase)
      psfp_pkg::PH_SECOND: begin
        if (rx == psfp_pkg::HDR_SECOND) begin
          phase_next       = psfp_pkg::PH_COLLECT;
          byte_index_next  = IDX_W'(psfp_pkg::FIRST_DATA_POS);
          running_sum_next = psfp_pkg::HDR_SUM;
        end else if (rx != psfp_pkg::HDR_FIRST) begin
          phase_next       = psfp_pkg::PH_HUNT;
          byte_index_next  = '0;
          running_sum_next = '0;
        end
      end
      psfp_pkg::PH_COLLECT: begin
        if (byte_index < CHK_IDX) begin
          running_sum_next = running_sum + {8'd0, rx};
        end
        if (byte_index == IDX_W'(psfp_pkg::PM1_HI_POS))  pm1_reg_next[15:8]  = rx;
        if (byte_index == IDX_W'(psfp_pkg::PM1_LO_POS))  pm1_reg_next[7:0]   = rx;
        if (byte_index == IDX_W'(psfp_pkg::PM25_HI_POS)) pm25_reg_next[15:8] = rx;
        if (byte_index == IDX_W'(psfp_pkg::PM25_LO_POS)) pm25_reg_next[7:0]  = rx;
        if (byte_index == IDX_W'(psfp_pkg::PM10_HI_POS)) pm10_reg_next[15:8] = rx;
        if (byte_index == IDX_W'(psfp_pkg::PM10_LO_POS)) pm10_reg_next[7:0]  = rx;
        if (byte_index == CHK_IDX) begin
          check_high_next = rx;
        end
        if (byte_index == LAST_IDX) begin
          // last byte: report and drop back to hunting
          emit             = 1'b1;
          phase_next       = psfp_pkg::PH_HUNT;
          byte_index_next  = '0;
          running_sum_next = '0;
        end else begin
          byte_index_next = byte_index + 1'b1;
        end
      end
      default: begin
        byte_index_next  = '0;
        running_sum_next = '0;
        phase_next = (rx == psfp_pkg::HDR_FIRST) ? psfp_pkg::PH_SECOND : psfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res.pm1_0       = pm1_reg;
    res.pm2_5       = pm25_reg;
    res.pm10        = pm10_reg;
    res.checksum_ok = ({check_high, rx} == running_sum);
  end

endmodule

`default_nettype wire

[design/psfp_out_reg.sv]
// Result register of the parser: holds one frame report until it is transferred.
// Depends on psfp_pkg.
`default_nettype none

module psfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire psfp_pkg::result_t res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output psfp_pkg::result_t      held
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

[design/particle_sensor_frame_parser_core.sv]
// Ordering: each byte is held in the input register until the parser steps on it; a frame report is registered.
// Throughput: one byte per cycle; a byte that closes a frame waits only while the
// result register still holds an untransferred report.
// Reset (rst, synchronous): clears the input and result valid flags and returns the
// parser to header hunting with counters and captured readings at zero.
`include "assert_macros.svh"
`default_nettype none

module particle_sensor_frame_parser_core #(
  parameter int FRAME_BYTES = psfp_pkg::FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      pm1_0,
  output logic [15:0]      pm2_5,
  output logic [15:0]      pm10,
  output logic             checksum_ok
);

  logic              q_valid;
  logic [7:0]        q_byte;
  logic              advance;
  logic              emit;
  logic              out_free;
  psfp_pkg::result_t res;
  psfp_pkg::result_t held;

  // step the parser unless a report would overwrite one still waiting
  assign advance = q_valid && (!emit || out_free);

  psfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  psfp_frame_fsm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .rx   (q_byte),
    .emit (emit),
    .res  (res)
  );

  psfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign pm1_0       = held.pm1_0;
  assign pm2_5       = held.pm2_5;
  assign pm10        = held.pm10;
  assign checksum_ok = held.checksum_ok;

  `PSFP_ASSERT(a_report_lands, (advance && emit) |=> out_valid, "frame report not registered")
  `PSFP_NEVER(a_ready_when_empty, !in_ready && !q_valid, "input stalled with empty register")
  `PSFP_ASSERT(a_byte_held, (q_valid && !advance) |=> (q_valid && $stable(q_byte)), "stalled byte lost")

endmodule

`default_nettype wire
